/* rtl/tmg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmg_pkg
// shared widths, register indexes, config type and the quarter-wave sine
// table builder for the torus mesh generator
// ----------------------------------------------------------------------------
package tmg_pkg;

  localparam int unsigned SINE_TABLE_BITS_DEF = 10;
  localparam int unsigned MAX_DIVISIONS       = 255;

  // largest quarter table over the legal table sizes (14 bits)
  localparam int unsigned SINE_TAB_MAX = 4096;

  localparam logic [7:0] MAX_COUNT =
    (MAX_DIVISIONS > 255) ? 8'd255 : 8'(MAX_DIVISIONS);

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 17;

  localparam logic [CFG_INDEX_W-1:0] REG_MAJOR_RADIUS     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MINOR_RADIUS     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STACK_COUNT      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SLICE_COUNT      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_STACK_RECIPROCAL = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SLICE_RECIPROCAL = 3'd5;

  localparam logic [0:0] ACTION_VERTEX = 1'b0;
  localparam logic [0:0] ACTION_QUAD   = 1'b1;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic [15:0] major_radius;
    logic [15:0] minor_radius;
    logic [7:0]  stack_count;
    logic [7:0]  slice_count;
    logic [16:0] stack_reciprocal;
    logic [16:0] slice_reciprocal;
  } cfg_t;

  // finished vertex or quad item handed to the output stage
  typedef struct packed {
    logic               action;
    logic               range_error;
    logic signed [17:0] pos_x;
    logic signed [17:0] pos_y;
    logic signed [17:0] pos_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [15:0]        corner_a;
    logic [15:0]        corner_c;
  } res_t;

  typedef logic [14:0] sine_tab_t [0:SINE_TAB_MAX];

  // series terms of sin: divide by (2n)(2n+1)
  function automatic longint unsigned series_div(input longint unsigned term,
                                                 input int unsigned n);
    longint unsigned q;
    case (n)
      1:       q = term / 6;
      2:       q = term / 20;
      3:       q = term / 42;
      4:       q = term / 72;
      5:       q = term / 110;
      6:       q = term / 156;
      7:       q = term / 210;
      8:       q = term / 272;
      default: q = term / 342;
    endcase
    return q;
  endfunction

  function automatic sine_tab_t sine_table(input int unsigned table_bits);
    sine_tab_t       tab;
    int unsigned     qbits;
    int unsigned     qsize;
    longint unsigned x;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned v;
    qbits = table_bits - 2;
    qsize = 1 << qbits;
    tab   = '{default: '0};
    for (int unsigned k = 0; k <= qsize; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) >> qbits;
      term = x;
      sum  = x;
      for (int unsigned n = 1; n <= 9; n++) begin
        term = (((term * x) >> 30) * x) >> 30;
        term = series_div(term, n);
        if (n % 2 == 1) begin
          sum = (sum > term) ? sum - term : 64'd0;
        end else begin
          sum = sum + term;
        end
      end
      v = (sum + 64'd32768) >> 16;
      if (v > 64'd16384) begin
        v = 64'd16384;
      end
      tab[k] = v[14:0];
    end
    tab[0]     = '0;
    tab[qsize] = 15'd16384;
    return tab;
  endfunction

endpackage

/* rtl/tmg_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmg_in_if
// input item channel: vertex or quad request with grid position
// ----------------------------------------------------------------------------
interface tmg_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] grid_row;
  logic [7:0] grid_col;

  modport source (output valid, action, grid_row, grid_col, input ready);
  modport sink   (input valid, action, grid_row, grid_col, output ready);
endinterface

/* rtl/tmg_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmg_out_if
// result item channel: vertex attributes or one triangle corner index
// ----------------------------------------------------------------------------
interface tmg_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] pos_x;
  logic signed [17:0] pos_y;
  logic signed [17:0] pos_z;
  logic [16:0]        tex_u;
  logic [16:0]        tex_v;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic [15:0]        vertex_index;
  logic               last;
  logic               range_error;

  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, normal_x, normal_y,
                  normal_z, vertex_index, last, range_error, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, normal_x, normal_y,
                  normal_z, vertex_index, last, range_error, output ready);
endinterface

/* rtl/tmg_vertex_pipe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmg_vertex_pipe
// six-stage pipeline: angles, sine lookup, products, ring sum, ring
// products, rounding and saturation; quad corners ride along
// ----------------------------------------------------------------------------
module tmg_vertex_pipe import tmg_pkg::*; #(
  parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  tmg_in_if.sink  in_chan,
  output logic    res_valid,
  output res_t    res,
  input  logic    res_take
);

  localparam int unsigned QB = SINE_TABLE_BITS - 2;
  localparam int unsigned TAB_IDX_W = $clog2(SINE_TAB_MAX + 1);
  localparam logic [QB:0] QFULL = {1'b1, {QB{1'b0}}};
  localparam sine_tab_t SINE_TAB = sine_table(SINE_TABLE_BITS);

  typedef struct packed {
    logic        action;
    logic        err;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [15:0] corner_a;
    logic [15:0] corner_c;
  } side_t;

  function automatic logic signed [15:0] sine_of(input logic [15:0] turn);
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [1:0]                 quad;
    logic [QB:0]                j;
    logic [14:0]                m;
    idx  = turn[15 -: SINE_TABLE_BITS];
    quad = idx[SINE_TABLE_BITS-1 -: 2];
    j    = quad[0] ? (QFULL - {1'b0, idx[QB-1:0]}) : {1'b0, idx[QB-1:0]};
    m    = SINE_TAB[TAB_IDX_W'(j)];
    return quad[1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  // round to nearest, ties away from zero
  function automatic logic signed [48:0] round_sh(input logic signed [48:0] v,
                                                  input int unsigned s);
    logic signed [48:0] bias;
    logic signed [48:0] sum;
    bias = (49'sd1 <<< (s - 1)) - (v[48] ? 49'sd1 : 49'sd0);
    sum  = v + bias;
    return sum >>> s;
  endfunction

  function automatic logic signed [17:0] sat18(input logic signed [48:0] v);
    logic signed [17:0] r;
    if (v > 49'sd131071) begin
      r = 18'sh1FFFF;
    end else if (v < -49'sd131072) begin
      r = 18'sh20000;
    end else begin
      r = v[17:0];
    end
    return r;
  endfunction

  logic en1, en2, en3, en4, en5, en6;

  // stage 1: angles and base corner
  logic        s1_valid, s1_action, s1_err;
  logic [24:0] s1_pu, s1_pv;
  logic [15:0] s1_a;
  logic [7:0]  s1_slices;

  // stage 2: sine and cosine
  logic               s2_valid;
  side_t              s2_side;
  logic signed [15:0] s2_cu, s2_su, s2_cv, s2_sv;

  // stage 3: products on the trig values
  logic               s3_valid;
  side_t              s3_side;
  logic signed [15:0] s3_cu, s3_su, s3_sv;
  logic signed [32:0] s3_rcv, s3_rsv;
  logic signed [31:0] s3_ncx, s3_ncy;

  // stage 4: ring radius and rounded tube terms
  logic               s4_valid;
  side_t              s4_side;
  logic signed [15:0] s4_cu, s4_su;
  logic signed [32:0] s4_ring;
  logic signed [17:0] s4_pz;
  logic signed [15:0] s4_nx, s4_ny, s4_nz;

  // stage 5: ring times ring-angle trig
  logic               s5_valid;
  side_t              s5_side;
  logic signed [48:0] s5_px, s5_py;
  logic signed [17:0] s5_pz;
  logic signed [15:0] s5_nx, s5_ny, s5_nz;

  // stage 6: final rounding and saturation
  logic               s6_valid;
  side_t              s6_side;
  logic signed [17:0] s6_px, s6_py, s6_pz;
  logic signed [15:0] s6_nx, s6_ny, s6_nz;

  logic [7:0]  stacks, slices;
  logic [15:0] row_span;
  logic        vtx_err, quad_err;

  assign en6 = !s6_valid || res_take;
  assign en5 = !s5_valid || en6;
  assign en4 = !s4_valid || en5;
  assign en3 = !s3_valid || en4;
  assign en2 = !s2_valid || en3;
  assign en1 = !s1_valid || en2;
  assign in_chan.ready = en1;

  always_comb begin
    stacks   = (cfg.stack_count > MAX_COUNT) ? MAX_COUNT : cfg.stack_count;
    slices   = (cfg.slice_count > MAX_COUNT) ? MAX_COUNT : cfg.slice_count;
    row_span = 16'(in_chan.grid_row * ({1'b0, slices} + 9'd1));
    vtx_err  = (in_chan.grid_row > stacks) || (in_chan.grid_col > slices);
    quad_err = (in_chan.grid_row >= stacks) || (in_chan.grid_col >= slices);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
    end else begin
      if (en1) s1_valid <= in_chan.valid;
      if (en2) s2_valid <= s1_valid;
      if (en3) s3_valid <= s2_valid;
      if (en4) s4_valid <= s3_valid;
      if (en5) s5_valid <= s4_valid;
      if (en6) s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_action <= in_chan.action;
      s1_err    <= (in_chan.action == ACTION_QUAD) ? quad_err : vtx_err;
      s1_pu     <= in_chan.grid_col * cfg.slice_reciprocal;
      s1_pv     <= in_chan.grid_row * cfg.stack_reciprocal;
      s1_a      <= row_span + {8'b0, in_chan.grid_col};
      s1_slices <= slices;
    end
    if (en2) begin
      s2_side.action   <= s1_action;
      s2_side.err      <= s1_err;
      s2_side.tex_u    <= (s1_pu > 25'd65536) ? 17'h10000 : s1_pu[16:0];
      s2_side.tex_v    <= (s1_pv > 25'd65536) ? 17'h10000 : s1_pv[16:0];
      s2_side.corner_a <= s1_a;
      s2_side.corner_c <= s1_a + {8'b0, s1_slices} + 16'd1;
      s2_cu <= sine_of(s1_pu[15:0] + 16'h4000);
      s2_su <= sine_of(s1_pu[15:0]);
      s2_cv <= sine_of(s1_pv[15:0] + 16'h4000);
      s2_sv <= sine_of(s1_pv[15:0]);
    end
    if (en3) begin
      s3_side <= s2_side;
      s3_cu   <= s2_cu;
      s3_su   <= s2_su;
      s3_sv   <= s2_sv;
      s3_rcv  <= $signed({1'b0, cfg.minor_radius}) * s2_cv;
      s3_rsv  <= $signed({1'b0, cfg.minor_radius}) * s2_sv;
      s3_ncx  <= s2_cv * s2_cu;
      s3_ncy  <= s2_cv * s2_su;
    end
    if (en4) begin
      s4_side <= s3_side;
      s4_cu   <= s3_cu;
      s4_su   <= s3_su;
      s4_ring <= $signed({3'b0, cfg.major_radius, 14'b0}) + s3_rcv;
      s4_pz   <= sat18(round_sh(49'(s3_rsv), 14));
      s4_nx   <= 16'(round_sh(49'(s3_ncx), 14));
      s4_ny   <= 16'(round_sh(49'(s3_ncy), 14));
      s4_nz   <= s3_sv;
    end
    if (en5) begin
      s5_side <= s4_side;
      s5_px   <= s4_ring * s4_cu;
      s5_py   <= s4_ring * s4_su;
      s5_pz   <= s4_pz;
      s5_nx   <= s4_nx;
      s5_ny   <= s4_ny;
      s5_nz   <= s4_nz;
    end
    if (en6) begin
      s6_side <= s5_side;
      s6_px   <= sat18(round_sh(s5_px, 28));
      s6_py   <= sat18(round_sh(s5_py, 28));
      s6_pz   <= s5_pz;
      s6_nx   <= s5_nx;
      s6_ny   <= s5_ny;
      s6_nz   <= s5_nz;
    end
  end

  assign res_valid = s6_valid;

  always_comb begin
    res.action      = s6_side.action;
    res.range_error = s6_side.err;
    res.pos_x       = s6_px;
    res.pos_y       = s6_py;
    res.pos_z       = s6_pz;
    res.tex_u       = s6_side.tex_u;
    res.tex_v       = s6_side.tex_v;
    res.normal_x    = s6_nx;
    res.normal_y    = s6_ny;
    res.normal_z    = s6_nz;
    res.corner_a    = s6_side.corner_a;
    res.corner_c    = s6_side.corner_c;
  end

endmodule

/* rtl/tmg_quad_serializer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmg_quad_serializer
// output register; vertex and error items leave in one beat, quad items
// leave as six corner indices A B C D C B
// ----------------------------------------------------------------------------
module tmg_quad_serializer import tmg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      res_valid,
  input  res_t      res,
  output logic      res_take,
  tmg_out_if.source out_chan
);

  localparam logic [2:0] LAST_BEAT = 3'd5;

  logic [2:0]  beat, beat_next;
  logic        quad_mode;
  logic        final_beat;
  logic        advance;
  logic [15:0] corner_a, corner_c;
  logic [15:0] corner_next;

  assign final_beat = !quad_mode || (beat == LAST_BEAT);
  assign res_take   = !out_chan.valid || (out_chan.ready && final_beat);
  assign advance    = out_chan.valid && out_chan.ready && !final_beat;
  assign beat_next  = beat + 3'd1;

  always_comb begin
    case (beat_next)
      3'd1:    corner_next = corner_a + 16'd1;
      3'd2:    corner_next = corner_c;
      3'd3:    corner_next = corner_c + 16'd1;
      3'd4:    corner_next = corner_c;
      default: corner_next = corner_a + 16'd1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_chan.valid <= 1'b0;
      quad_mode      <= 1'b0;
      beat           <= '0;
    end else if (res_take) begin
      out_chan.valid <= res_valid;
      quad_mode      <= res_valid && (res.action == ACTION_QUAD) && !res.range_error;
      beat           <= '0;
    end else if (advance) begin
      beat <= beat_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      corner_a <= res.corner_a;
      corner_c <= res.corner_c;
      out_chan.range_error <= res.range_error;
      if (res.range_error || res.action == ACTION_QUAD) begin
        out_chan.pos_x        <= '0;
        out_chan.pos_y        <= '0;
        out_chan.pos_z        <= '0;
        out_chan.tex_u        <= '0;
        out_chan.tex_v        <= '0;
        out_chan.normal_x     <= '0;
        out_chan.normal_y     <= '0;
        out_chan.normal_z     <= '0;
        out_chan.vertex_index <= res.range_error ? 16'd0 : res.corner_a;
        out_chan.last         <= res.range_error;
      end else begin
        out_chan.pos_x        <= res.pos_x;
        out_chan.pos_y        <= res.pos_y;
        out_chan.pos_z        <= res.pos_z;
        out_chan.tex_u        <= res.tex_u;
        out_chan.tex_v        <= res.tex_v;
        out_chan.normal_x     <= res.normal_x;
        out_chan.normal_y     <= res.normal_y;
        out_chan.normal_z     <= res.normal_z;
        out_chan.vertex_index <= '0;
        out_chan.last         <= 1'b1;
      end
    end else if (advance) begin
      out_chan.vertex_index <= corner_next;
      out_chan.last         <= (beat_next == LAST_BEAT);
    end
  end

endmodule

/* rtl/torus_mesh_generator_core.sv */
`timescale 1ns / 1ps
// path: a result item passes through six pipeline stages, the first loaded at the edge
// accepting its item, and then the output register. throughput: one vertex item per cycle
// while the output is not stalled; a quad item holds the output register until its last
// corner index has left, so input behind it waits.
// reset: synchronous; clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
// torus_mesh_generator_core
// torus tessellator: vertex positions, normals and texture coordinates, and
// quad corner indices, with a plain register write port
// ----------------------------------------------------------------------------
module torus_mesh_generator_core import tmg_pkg::*; #(
  parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  tmg_in_if.sink                 in_chan,
  tmg_out_if.source              out_chan
);

  cfg_t cfg;
  logic res_valid;
  logic res_take;
  res_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.major_radius     <= 16'd256;
      cfg.minor_radius     <= 16'd64;
      cfg.stack_count      <= 8'd16;
      cfg.slice_count      <= 8'd16;
      cfg.stack_reciprocal <= 17'd4096;
      cfg.slice_reciprocal <= 17'd4096;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAJOR_RADIUS:     cfg.major_radius     <= cfg_data[15:0];
        REG_MINOR_RADIUS:     cfg.minor_radius     <= cfg_data[15:0];
        REG_STACK_COUNT:      cfg.stack_count      <= cfg_data[7:0];
        REG_SLICE_COUNT:      cfg.slice_count      <= cfg_data[7:0];
        REG_STACK_RECIPROCAL: cfg.stack_reciprocal <= cfg_data;
        REG_SLICE_RECIPROCAL: cfg.slice_reciprocal <= cfg_data;
        default: ;
      endcase
    end
  end

  tmg_vertex_pipe #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_pipe (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_chan  (in_chan),
    .res_valid(res_valid),
    .res      (res),
    .res_take (res_take)
  );

  tmg_quad_serializer u_ser (
    .clk      (clk),
    .rst      (rst),
    .res_valid(res_valid),
    .res      (res),
    .res_take (res_take),
    .out_chan (out_chan)
  );

endmodule
